>>> sv/assert_macros.svh
// Assertion macros used by the converter core module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CHK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/thdc_pkg.sv
// Shared types, constants and the log table generator for the thermistor converter.
`default_nettype none

package thdc_pkg;

    // Width of the values whose logarithm is taken.
    localparam int X_W   = 23;
    localparam int E_W   = $clog2(X_W);
    // Logarithms are unsigned Q24, table entries cover ln(m) for m in [1,2].
    localparam int LN_W  = 29;
    localparam int ROM_W = 24;

    // Number of interpolation steps in the log table; a power of two.
    localparam int LN_TABLE_DEPTH = 64;

    localparam logic [63:0]     LN2_Q32 = 64'd2977044472;
    localparam logic [LN_W-1:0] LN2_Q24 = LN_W'((LN2_Q32 + 64'd128) >> 8);

    // Configuration port.
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 48;

    localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_UV   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_OHMS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_C      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRIM_GAIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TRIM_OFFSET = 3'd6;

    // Output range in millidegrees.
    localparam logic signed [20:0] T_MIN_MDEG = -21'sd273150;
    localparam logic signed [20:0] T_MAX_MDEG = 21'sd1000000;

    // Control carried alongside each beat in the pipeline.
    typedef struct packed {
        logic valid;
        logic err;
    } tag_t;

    // One log table entry: ln(1 + i/2^k) in Q24, from log2 by repeated squaring.
    // Evaluated at elaboration only.
    function automatic logic [ROM_W-1:0] ln_rom_value(input int unsigned i,
                                                      input int unsigned k);
        logic [63:0] m;
        logic [63:0] y;
        logic [63:0] r;
        logic [63:0] prod;
        int          b;
        m = (64'd1 << 30) + (64'(i) << (30 - k));
        r = '0;
        if (m >= (64'd2 << 30))
        begin
            r = 64'd1 << 30;
        end
        else
        begin
            y = m;
            for (b = 29; b >= 0; b--)
            begin
                y = (y * y) >> 30;
                if (y >= (64'd2 << 30))
                begin
                    y    = y >> 1;
                    r[b] = 1'b1;
                end
            end
        end
        prod = r * LN2_Q32 + (64'd1 << 37);
        return ROM_W'(prod >> 38);
    endfunction

endpackage

`default_nettype wire

>>> sv/thdc_ln.sv
// Three-stage natural logarithm of a positive integer by table and interpolation.
`default_nettype none

module thdc_ln
    import thdc_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            en,
    input  wire logic [X_W-1:0]  x,
    output logic      [LN_W-1:0] ln
);

    localparam int IDX_W = $clog2(LN_TABLE_DEPTH);
    localparam int FR_W  = X_W - 1;
    localparam int RL_W  = FR_W - IDX_W;

    // Constant table of ln(m) over the mantissa range, one more point than steps.
    logic [ROM_W-1:0] rom [0:LN_TABLE_DEPTH];

    for (genvar gi = 0; gi <= LN_TABLE_DEPTH; gi++)
    begin : g_rom
        localparam logic [ROM_W-1:0] ROM_VAL = ln_rom_value(gi, IDX_W);
        assign rom[gi] = ROM_VAL;
    end

    logic [E_W-1:0]   e1_next, e1_reg, e2_reg;
    logic [IDX_W-1:0] idx1_next, idx1_reg;
    logic [RL_W-1:0]  rl1_next, rl1_reg, rl2_reg;
    logic [X_W-1:0]   norm;
    logic [ROM_W-1:0] base2_next, base2_reg;
    logic [ROM_W-1:0] diff2_next, diff2_reg;
    logic [ROM_W+RL_W-1:0] interp;
    logic [LN_W-1:0]  ln_next, ln_reg;

    // Stage one: find the leading one and normalise the mantissa.
    always_comb
    begin
        e1_next = '0;
        for (int i = 1; i < X_W; i++)
        begin
            if (x[i])
            begin
                e1_next = E_W'(i);
            end
        end
        norm      = x << (E_W'(FR_W) - e1_next);
        idx1_next = norm[FR_W-1 -: IDX_W];
        rl1_next  = norm[RL_W-1:0];
    end

    // Stage two: read the two neighbouring table points.
    always_comb
    begin
        base2_next = rom[{1'b0, idx1_reg}];
        diff2_next = rom[(IDX_W+1)'({1'b0, idx1_reg} + 1'b1)] - rom[{1'b0, idx1_reg}];
    end

    // Stage three: interpolate and add the exponent term.
    always_comb
    begin
        interp  = diff2_reg * rl2_reg;
        ln_next = LN_W'(LN_W'(e2_reg) * LN2_Q24) + LN_W'(base2_reg)
                + LN_W'(interp[ROM_W+RL_W-1:RL_W]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg    <= e1_next;
            idx1_reg  <= idx1_next;
            rl1_reg   <= rl1_next;
            e2_reg    <= e1_reg;
            rl2_reg   <= rl1_reg;
            base2_reg <= base2_next;
            diff2_reg <= diff2_next;
            ln_reg    <= ln_next;
        end
    end

    assign ln = ln_reg;

endmodule

`default_nettype wire

>>> sv/thdc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module thdc_div
    import thdc_pkg::*;
#(
    parameter int QW = 50
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire tag_t          tag_in,
    input  wire logic [63:0]   dividend,
    input  wire logic [62:0]   divisor,
    output tag_t               tag_out,
    output logic      [QW-1:0] quotient
);

    // Per stage: partial remainder, dividend bits still to come merged with
    // quotient bits already found, divisor and the beat's tag.
    logic [62:0]   rem_reg  [QW];
    logic [62:0]   rem_next [QW];
    logic [QW-1:0] lq_reg   [QW];
    logic [QW-1:0] lq_next  [QW];
    logic [62:0]   d_reg    [QW];
    tag_t          tag_reg  [QW];

    always_comb
    begin
        logic [62:0]   src_rem;
        logic [QW-1:0] src_lq;
        logic [62:0]   src_d;
        logic [63:0]   cat;
        logic          ge;
        for (int j = 0; j < QW; j++)
        begin
            if (j == 0)
            begin
                src_rem = 63'(dividend >> QW);
                src_lq  = dividend[QW-1:0];
                src_d   = divisor;
            end
            else
            begin
                src_rem = rem_reg[j-1];
                src_lq  = lq_reg[j-1];
                src_d   = d_reg[j-1];
            end
            cat         = {src_rem, src_lq[QW-1]};
            ge          = (cat >= {1'b0, src_d});
            rem_next[j] = ge ? 63'(cat - {1'b0, src_d}) : cat[62:0];
            lq_next[j]  = {src_lq[QW-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < QW; j++)
            begin
                rem_reg[j] <= rem_next[j];
                lq_reg[j]  <= lq_next[j];
                d_reg[j]   <= (j == 0) ? divisor : d_reg[j-1];
            end
        end
    end

    // Tags travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < QW; j++)
            begin
                tag_reg[j] <= '0;
            end
        end
        else if (en)
        begin
            for (int j = 0; j < QW; j++)
            begin
                tag_reg[j] <= (j == 0) ? tag_in : tag_reg[j-1];
            end
        end
    end

    assign tag_out  = tag_reg[QW-1];
    assign quotient = lq_reg[QW-1];

endmodule

`default_nettype wire

>>> sv/thermistor_divider_to_celsius_core.sv
// Thermistor divider to Celsius converter, Steinhart-Hart in fixed point.
// The divider resolves one quotient bit per stage; a new beat is taken every
// cycle while the output is not stalled.
// Reset clears every valid bit and loads the default configuration registers.
`default_nettype none
`include "assert_macros.svh"

module thermistor_divider_to_celsius_core
    import thdc_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 40
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic signed [23:0]    node_uv,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic signed [20:0]         temp_mdeg,
    output logic                       status
);

    localparam int QW = COEF_FRAC_BITS + 10;
    localparam logic [63:0] DIV_NUM = 64'd1000 << COEF_FRAC_BITS;
    localparam logic signed [64:0] SUM_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SUM_MIN = -65'sh0_7FFF_FFFF_FFFF_FFFF;

    // Configuration registers.
    logic        [22:0] supply_uv_reg;
    logic        [19:0] fixed_ohms_reg;
    logic signed [47:0] coef_a_reg;
    logic signed [47:0] coef_b_reg;
    logic signed [47:0] coef_c_reg;
    logic        [18:0] trim_gain_reg;
    logic signed [17:0] trim_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supply_uv_reg   <= 23'd4910000;
            fixed_ohms_reg  <= 20'd9880;
            coef_a_reg      <= -48'sd4011570000;
            coef_b_reg      <= 48'sd1059483000;
            coef_c_reg      <= -48'sd2659587;
            trim_gain_reg   <= 19'd65536;
            trim_offset_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SUPPLY_UV:   supply_uv_reg   <= cfg_data[22:0];
                REG_FIXED_OHMS:  fixed_ohms_reg  <= cfg_data[19:0];
                REG_COEF_A:      coef_a_reg      <= cfg_data[47:0];
                REG_COEF_B:      coef_b_reg      <= cfg_data[47:0];
                REG_COEF_C:      coef_c_reg      <= cfg_data[47:0];
                REG_TRIM_GAIN:   trim_gain_reg   <= cfg_data[18:0];
                REG_TRIM_OFFSET: trim_offset_reg <= cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline moves together unless a finished beat is held.
    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // Coefficient magnitudes.
    logic [47:0] cb_mag;
    logic [47:0] cc_mag;

    assign cb_mag = coef_b_reg[47] ? 48'(-coef_b_reg) : 48'(coef_b_reg);
    assign cc_mag = coef_c_reg[47] ? 48'(-coef_c_reg) : 48'(coef_c_reg);

    // Stage one: clamp the node voltage and flag unusable inputs.
    logic signed [24:0] v_lo, v_cl, sup_m, sv_full;
    logic [X_W-1:0]     v1_next, v1_reg, sv1_next, sv1_reg;
    logic               err1;
    tag_t               tag_s1_reg;

    always_comb
    begin
        v_lo     = (node_uv < 24'sd1000) ? 25'sd1000 : 25'(node_uv);
        sup_m    = $signed({2'b00, supply_uv_reg}) - 25'sd1000;
        v_cl     = (v_lo > sup_m) ? sup_m : v_lo;
        sv_full  = $signed({2'b00, supply_uv_reg}) - v_cl;
        err1     = (v_cl <= 25'sd0) || (fixed_ohms_reg == '0);
        v1_next  = v_cl[X_W-1:0];
        sv1_next = sv_full[X_W-1:0];
    end

    // Three logarithms in parallel.
    logic [LN_W-1:0] ln_f, ln_s, ln_v;
    tag_t            tag_ln_reg [3];

    thdc_ln u_ln_fixed
    (
        .clk (clk),
        .en  (en),
        .x   ({3'b000, fixed_ohms_reg}),
        .ln  (ln_f)
    );

    thdc_ln u_ln_upper
    (
        .clk (clk),
        .en  (en),
        .x   (sv1_reg),
        .ln  (ln_s)
    );

    thdc_ln u_ln_lower
    (
        .clk (clk),
        .en  (en),
        .x   (v1_reg),
        .ln  (ln_v)
    );

    // Stage five: ln R as sign and magnitude.
    logic signed [30:0] lnr;
    logic [29:0]        mag_next, mag5_reg;
    logic               neg5_reg, neg6_reg, neg7_reg, neg8_reg;
    logic               neg9_reg, neg10_reg, neg11_reg, neg12_reg;
    tag_t               tag_s5_reg;

    always_comb
    begin
        lnr      = $signed({2'b00, ln_f}) + $signed({2'b00, ln_s}) - $signed({2'b00, ln_v});
        mag_next = lnr[30] ? 30'(-lnr) : 30'(lnr);
    end

    // Stage six: square of ln R and the two halves of the B product.
    logic [59:0] sq6_reg;
    logic [53:0] bl6_reg, bh6_reg;
    logic [29:0] mag6_reg, mag7_reg, mag8_reg;
    tag_t        tag_s6_reg;

    // Stage seven: scaled square and B product magnitude.
    logic [35:0] ln2_7_reg;
    logic [55:0] bmag7_reg, bmag8_reg, bmag9_reg, bmag10_reg, bmag11_reg, bmag12_reg;
    tag_t        tag_s7_reg;

    // Stage eight: two halves of the cube product.
    logic [53:0] p0_8_reg;
    logic [41:0] p1_8_reg;
    tag_t        tag_s8_reg;

    // Stage nine: cube of ln R.
    logic [41:0] ln3_next, ln3_9_reg;
    tag_t        tag_s9_reg;

    // Stage ten: four partial products of C times the cube.
    logic [44:0] c00_reg, c01_reg, c10_reg, c11_reg;
    tag_t        tag_s10_reg;

    // Stage eleven and twelve: assemble the full C product.
    logic [66:0] ca_reg, cb_reg;
    logic [90:0] cp_reg;
    tag_t        tag_s11_reg, tag_s12_reg;

    assign ln3_next = 42'(43'(p1_8_reg) + 43'(p0_8_reg[53:24]));

    // Stage thirteen: saturate the C term and add A to the B term.
    logic [62:0]        cmag;
    logic               bneg, cneg;
    logic signed [63:0] bterm;
    logic signed [63:0] ab_next, ab_reg, ct_next, ct_reg;
    tag_t               tag_s13_reg;

    always_comb
    begin
        bneg    = coef_b_reg[47] ^ neg12_reg;
        cneg    = coef_c_reg[47] ^ neg12_reg;
        cmag    = (|cp_reg[90:87]) ? {63{1'b1}} : cp_reg[86:24];
        bterm   = bneg ? -$signed({8'b0, bmag12_reg}) : $signed({8'b0, bmag12_reg});
        ct_next = cneg ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
        ab_next = 64'(coef_a_reg) + bterm;
    end

    // Stage fourteen: saturating sum gives the inverse temperature.
    logic signed [64:0] sum65;
    logic signed [63:0] inv_next, inv_reg;
    logic               inv_bad;
    tag_t               tag_s14_reg;

    always_comb
    begin
        sum65 = 65'(ab_reg) + 65'(ct_reg);
        if (sum65 > SUM_MAX)
        begin
            inv_next = SUM_MAX[63:0];
        end
        else if (sum65 < SUM_MIN)
        begin
            inv_next = SUM_MIN[63:0];
        end
        else
        begin
            inv_next = sum65[63:0];
        end
        inv_bad = inv_next[63] || (inv_next == '0);
    end

    // Stage fifteen: dividend with half the divisor added for rounding.
    logic [63:0] dividend_reg;
    logic [62:0] divisor_reg;
    tag_t        tag_s15_reg;
    tag_t        tag_div;
    logic [QW-1:0] quot;

    thdc_div #(.QW(QW)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .tag_in   (tag_s15_reg),
        .dividend (dividend_reg),
        .divisor  (divisor_reg),
        .tag_out  (tag_div),
        .quotient (quot)
    );

    // Stage sixteen: Kelvin to Celsius and the pre-gain limit.
    logic signed [59:0] tdiff;
    logic signed [41:0] t16_next, t16_reg;
    tag_t               tag_s16_reg;

    always_comb
    begin
        tdiff    = $signed(60'(quot)) - 60'sd273150;
        t16_next = (tdiff > 60'sd1099511627776) ? 42'sd1099511627776 : 42'(tdiff);
    end

    // Stage seventeen: trim gain as two partial products.
    logic        [39:0] pl_reg;
    logic signed [40:0] ph_reg;
    tag_t               tag_s17_reg;

    // Stage eighteen: full gain product.
    logic signed [61:0] p_next, p_reg;
    tag_t               tag_s18_reg;

    assign p_next = (62'(ph_reg) <<< 21) + $signed({22'b0, pl_reg});

    // Output stage: round, add the offset and saturate; a flagged beat gives zero.
    logic signed [61:0] rnd;
    logic signed [46:0] tsum;
    logic signed [20:0] temp_next, temp_reg;
    logic               status_next, status_reg;

    always_comb
    begin
        rnd  = (p_reg + 62'sd32768) >>> 16;
        tsum = 47'($signed(rnd[45:0])) + 47'(trim_offset_reg);
        if (tag_s18_reg.err)
        begin
            temp_next   = '0;
            status_next = 1'b1;
        end
        else if (tsum < 47'(T_MIN_MDEG))
        begin
            temp_next   = T_MIN_MDEG;
            status_next = 1'b1;
        end
        else if (tsum > 47'(T_MAX_MDEG))
        begin
            temp_next   = T_MAX_MDEG;
            status_next = 1'b1;
        end
        else
        begin
            temp_next   = 21'(tsum);
            status_next = 1'b0;
        end
    end

    // Payload registers of all stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg       <= v1_next;
            sv1_reg      <= sv1_next;
            mag5_reg     <= mag_next;
            neg5_reg     <= lnr[30];
            sq6_reg      <= mag5_reg * mag5_reg;
            bl6_reg      <= cb_mag[23:0] * mag5_reg;
            bh6_reg      <= cb_mag[47:24] * mag5_reg;
            mag6_reg     <= mag5_reg;
            neg6_reg     <= neg5_reg;
            ln2_7_reg    <= sq6_reg[59:24];
            bmag7_reg    <= 56'(bh6_reg) + 56'(bl6_reg[53:24]);
            mag7_reg     <= mag6_reg;
            neg7_reg     <= neg6_reg;
            p0_8_reg     <= ln2_7_reg[23:0] * mag7_reg;
            p1_8_reg     <= ln2_7_reg[35:24] * mag7_reg;
            mag8_reg     <= mag7_reg;
            bmag8_reg    <= bmag7_reg;
            neg8_reg     <= neg7_reg;
            ln3_9_reg    <= ln3_next;
            bmag9_reg    <= bmag8_reg;
            neg9_reg     <= neg8_reg;
            c00_reg      <= cc_mag[23:0] * ln3_9_reg[20:0];
            c01_reg      <= cc_mag[23:0] * ln3_9_reg[41:21];
            c10_reg      <= cc_mag[47:24] * ln3_9_reg[20:0];
            c11_reg      <= cc_mag[47:24] * ln3_9_reg[41:21];
            bmag10_reg   <= bmag9_reg;
            neg10_reg    <= neg9_reg;
            ca_reg       <= 67'(c00_reg) + (67'(c01_reg) << 21);
            cb_reg       <= 67'(c10_reg) + (67'(c11_reg) << 21);
            bmag11_reg   <= bmag10_reg;
            neg11_reg    <= neg10_reg;
            cp_reg       <= 91'(ca_reg) + (91'(cb_reg) << 24);
            bmag12_reg   <= bmag11_reg;
            neg12_reg    <= neg11_reg;
            ab_reg       <= ab_next;
            ct_reg       <= ct_next;
            inv_reg      <= inv_next;
            dividend_reg <= DIV_NUM + 64'(inv_reg[63:1]);
            divisor_reg  <= inv_reg[62:0];
            t16_reg      <= t16_next;
            pl_reg       <= t16_reg[20:0] * trim_gain_reg;
            ph_reg       <= $signed(t16_reg[41:21]) * $signed({1'b0, trim_gain_reg});
            p_reg        <= p_next;
            temp_reg     <= temp_next;
            status_reg   <= status_next;
        end
    end

    // Valid and error bits of all stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_s1_reg    <= '0;
            tag_ln_reg[0] <= '0;
            tag_ln_reg[1] <= '0;
            tag_ln_reg[2] <= '0;
            tag_s5_reg    <= '0;
            tag_s6_reg    <= '0;
            tag_s7_reg    <= '0;
            tag_s8_reg    <= '0;
            tag_s9_reg    <= '0;
            tag_s10_reg   <= '0;
            tag_s11_reg   <= '0;
            tag_s12_reg   <= '0;
            tag_s13_reg   <= '0;
            tag_s14_reg   <= '0;
            tag_s15_reg   <= '0;
            tag_s16_reg   <= '0;
            tag_s17_reg   <= '0;
            tag_s18_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            tag_s1_reg.valid <= in_valid;
            tag_s1_reg.err   <= err1;
            tag_ln_reg[0]    <= tag_s1_reg;
            tag_ln_reg[1]    <= tag_ln_reg[0];
            tag_ln_reg[2]    <= tag_ln_reg[1];
            tag_s5_reg       <= tag_ln_reg[2];
            tag_s6_reg       <= tag_s5_reg;
            tag_s7_reg       <= tag_s6_reg;
            tag_s8_reg       <= tag_s7_reg;
            tag_s9_reg       <= tag_s8_reg;
            tag_s10_reg      <= tag_s9_reg;
            tag_s11_reg      <= tag_s10_reg;
            tag_s12_reg      <= tag_s11_reg;
            tag_s13_reg      <= tag_s12_reg;
            tag_s14_reg.valid <= tag_s13_reg.valid;
            tag_s14_reg.err   <= tag_s13_reg.err || inv_bad;
            tag_s15_reg      <= tag_s14_reg;
            tag_s16_reg      <= tag_div;
            tag_s17_reg      <= tag_s16_reg;
            tag_s18_reg      <= tag_s17_reg;
            out_valid_reg    <= tag_s18_reg.valid;
        end
    end

    assign out_valid = out_valid_reg;
    assign temp_mdeg = temp_reg;
    assign status    = status_reg;

    // A held output beat freezes the whole pipeline and the input side.
    `CHK_IMPLY(a_hold_blocks_input, out_valid_reg && out_stall, in_stall,
               "input beat taken while the output beat is held")
    `CHK_NEXT(a_pipe_frozen, !en, $stable(tag_s15_reg),
              "pipeline moved while the output beat was held")
    // A flagged result is either zero or pinned to one of the range limits.
    `CHK_IMPLY(a_status_value, out_valid_reg && status_reg,
               temp_reg == '0 || temp_reg == T_MIN_MDEG || temp_reg == T_MAX_MDEG,
               "flagged result carries an unexpected temperature")

endmodule

`default_nettype wire
